>>> rtl/core/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Depends on nothing; imported by wsfd_parser and the top level.
package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HEAD1   = 3'd0,
        PH_HEAD2   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    localparam logic [6:0] LEN_MASK    = 7'h7f;
    localparam logic [3:0] OPCODE_MASK = 4'h0f;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic       frame_end;
        logic       message_end;
        logic       empty_frame;
    } t_result;

endpackage

>>> rtl/core/websocket_frame_deframer_unit.sv
// WebSocket frame deframer: input register, header parser and result register.
// Depends on wsfd_pkg and wsfd_parser.
//
// Usage:
//   Slave channel (i_s_tvalid/o_s_tready/i_s_tdata) takes the received byte
//   stream, one byte per request. Master channel (o_m_tvalid/i_m_tready)
//   gives one request per payload byte, plus one empty request for each
//   zero-length frame; header, length and key bytes give none.
//   o_m_tdata carries the unmasked byte and the frame opcode, o_m_tlast
//   marks the last byte of a frame, o_m_tuser flags message end and an
//   empty frame.
//   Path: an accepted byte waits in the input register, is parsed once the result
//   register is free, and its result is registered in the result register,
//   which drives the master channel.
//   Throughput: one byte per cycle while the result register is free; the parser's
//   next state, the 64-bit length count compare and the key select are combinational.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to the first header byte.
//   When the receiver stalls, the result register holds; the input register
//   still fills if empty, so at most one further byte is taken before o_s_tready drops.
module websocket_frame_deframer_unit
    import wsfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] data_byte, [11:8] frame_opcode, [15:12] zero
    output logic        o_m_tlast,   // frame_end
    output logic [1:0]  o_m_tuser    // [0] message_end, [1] empty_frame
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       step;
    logic       out_free;
    t_result    res;
    t_result    r_out;

    assign out_free   = !r_out.valid || i_m_tready;
    assign step       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    wsfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // advance the result register whenever it is free; drop empty steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (out_free) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out.valid;
    assign o_m_tdata  = {4'd0, r_out.frame_opcode, r_out.data_byte};
    assign o_m_tlast  = r_out.frame_end;
    assign o_m_tuser  = {r_out.empty_frame, r_out.message_end};

endmodule

>>> rtl/core/wsfd_parser.sv
// Frame header parser and payload unmasking for one byte per step.
// Depends on wsfd_pkg; instantiated by websocket_frame_deframer_unit.
module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_first_header, n_first_header;
    logic        r_mask_present, n_mask_present;
    logic [3:0]  r_left, n_left;
    logic [63:0] r_length, n_length;
    logic [63:0] r_received, n_received;
    logic [7:0]  r_key [4];
    logic [1:0]  r_mask_pos, n_mask_pos;
    logic        key_we;
    logic [1:0]  key_idx;
    logic [6:0]  len_code;
    logic [3:0]  left_dec;
    logic [63:0] recv_inc;
    logic        fin;

    assign len_code = i_byte[6:0] & LEN_MASK;
    assign left_dec = (r_left != 4'd0) ? r_left - 4'd1 : r_left;
    assign recv_inc = r_received + 64'd1;
    assign key_idx  = 2'd0 - r_left[1:0];
    assign fin      = r_first_header[7];

    always_comb begin
        n_phase        = r_phase;
        n_first_header = r_first_header;
        n_mask_present = r_mask_present;
        n_left         = r_left;
        n_length       = r_length;
        n_received     = r_received;
        n_mask_pos     = r_mask_pos;
        key_we         = 1'b0;
        o_res              = '0;
        o_res.frame_opcode = r_first_header[3:0] & OPCODE_MASK;
        case (r_phase)
            PH_HEAD2: begin
                n_mask_present = i_byte[7];
                n_mask_pos     = 2'd0;
                n_received     = '0;
                n_length       = '0;
                if (len_code == LEN_CODE_16) begin
                    n_left  = EXT_BYTES_16;
                    n_phase = PH_EXTLEN;
                end else if (len_code == LEN_CODE_64) begin
                    n_left  = EXT_BYTES_64;
                    n_phase = PH_EXTLEN;
                end else begin
                    n_length = {57'd0, len_code};
                    if (i_byte[7]) begin
                        n_phase = PH_MASK;
                        n_left  = KEY_BYTES;
                    end else if (len_code == 7'd0) begin
                        n_phase           = PH_HEAD1;
                        o_res.valid       = 1'b1;
                        o_res.frame_end   = 1'b1;
                        o_res.message_end = fin;
                        o_res.empty_frame = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                n_length = {r_length[55:0], i_byte};
                n_left   = left_dec;
                if (left_dec == 4'd0) begin
                    if (r_mask_present) begin
                        n_phase = PH_MASK;
                        n_left  = KEY_BYTES;
                    end else if (n_length == 64'd0) begin
                        n_phase           = PH_HEAD1;
                        o_res.valid       = 1'b1;
                        o_res.frame_end   = 1'b1;
                        o_res.message_end = fin;
                        o_res.empty_frame = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_MASK: begin
                key_we = 1'b1;
                n_left = left_dec;
                if (left_dec == 4'd0) begin
                    n_mask_pos = 2'd0;
                    if (r_length == 64'd0) begin
                        n_phase           = PH_HEAD1;
                        o_res.valid       = 1'b1;
                        o_res.frame_end   = 1'b1;
                        o_res.message_end = fin;
                        o_res.empty_frame = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_res.valid     = 1'b1;
                o_res.data_byte = i_byte;
                if (r_mask_present) begin
                    o_res.data_byte = i_byte ^ r_key[r_mask_pos];
                    n_mask_pos      = r_mask_pos + 2'd1;
                end
                n_received        = recv_inc;
                o_res.frame_end   = (recv_inc >= r_length);
                o_res.message_end = o_res.frame_end & fin;
                if (o_res.frame_end) begin
                    n_phase = PH_HEAD1;
                end
            end
            default: begin
                // first header byte; undefined phases land here too
                n_first_header = i_byte;
                n_phase        = PH_HEAD2;
            end
        endcase
        if (!i_step) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEAD1;
            r_first_header <= '0;
            r_mask_present <= 1'b0;
            r_left         <= '0;
            r_length       <= '0;
            r_received     <= '0;
            r_mask_pos     <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_first_header <= n_first_header;
            r_mask_present <= n_mask_present;
            r_left         <= n_left;
            r_length       <= n_length;
            r_received     <= n_received;
            r_mask_pos     <= n_mask_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && key_we) begin
            r_key[key_idx] <= i_byte;
        end
    end

    a_extlen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EXTLEN |-> r_left != 4'd0)
        else $error("extended length phase with no bytes due");

    a_mask_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_MASK |-> r_mask_present && r_left != 4'd0)
        else $error("mask key phase entered without mask flag or count");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.empty_frame |-> o_res.frame_end && o_res.data_byte == 8'd0)
        else $error("empty frame result malformed");

    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.valid && o_res.frame_end |=> r_phase == PH_HEAD1)
        else $error("parser did not return to header after frame end");

endmodule

>>> verif/websocket_frame_deframer_unit_tb.sv
// Testbench for websocket_frame_deframer_unit: streams frames one byte per request,
// predicts each payload or empty-frame result and checks the master stream.
// Depends on wsfd_pkg and the deframer RTL.
module websocket_frame_deframer_unit_tb;
    import wsfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_RSVD   = 4'h3;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;
    localparam logic [3:0] OP_TOP    = 4'hF;

    localparam int RANDOM_BYTES   = 150;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_form;

    typedef struct {
        logic [7:0] data_byte;
        logic [3:0] opcode;
        logic       frame_end;
        logic       message_end;
        logic       empty_frame;
    } t_deframe_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] rx_byte
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [7:0] data_byte, [11:8] frame_opcode, [15:12] zero
    logic        o_m_tlast;   // frame_end
    logic [1:0]  o_m_tuser;   // [0] message_end, [1] empty_frame

    websocket_frame_deframer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // Parser state as the deframer should hold it
    t_phase      phase;
    logic [7:0]  hdr0;
    logic        masked;
    logic [3:0]  hdr_left;
    logic [63:0] frame_len;
    logic [63:0] payload_seen;
    logic [7:0]  mask_key [4];
    logic [1:0]  key_pos;

    t_deframe_result expected_results[$];

    int gap_pct;
    int stall_pct;
    int stall_left;
    int n_errors;
    int n_bytes;
    int n_frames;
    int n_results;
    int n_empty;
    int n_ext64;

    logic [3:0] known_ops [6] = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void queue_result(input logic [7:0] d, input logic fend,
                                         input logic empty);
        t_deframe_result r;
        r.data_byte   = d;
        r.opcode      = hdr0[3:0];
        r.frame_end   = fend;
        r.message_end = fend & hdr0[7];
        r.empty_frame = empty;
        expected_results = {expected_results, r};
    endfunction

    // Length complete: fetch the key if masked, else close an empty frame or start payload
    function automatic void finish_length();
        if (masked && phase != PH_MASK) begin
            phase    = PH_MASK;
            hdr_left = KEY_BYTES;
        end else if (frame_len == 64'd0) begin
            phase = PH_HEAD1;
            queue_result(8'h00, 1'b1, 1'b1);
        end else begin
            phase = PH_PAYLOAD;
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [1:0] key_idx;
        logic [7:0] d;
        logic       fend;
        case (phase)
            PH_HEAD2: begin
                masked       = b[7];
                key_pos      = 2'd0;
                payload_seen = 64'd0;
                frame_len    = 64'd0;
                if (b[6:0] == LEN_CODE_16) begin
                    hdr_left = EXT_BYTES_16;
                    phase    = PH_EXTLEN;
                end else if (b[6:0] == LEN_CODE_64) begin
                    hdr_left = EXT_BYTES_64;
                    phase    = PH_EXTLEN;
                end else begin
                    frame_len = {57'd0, b[6:0]};
                    finish_length();
                end
            end
            PH_EXTLEN: begin
                frame_len = {frame_len[55:0], b};
                if (hdr_left != 4'd0) hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0) finish_length();
            end
            PH_MASK: begin
                key_idx           = 2'd0 - hdr_left[1:0];
                mask_key[key_idx] = b;
                if (hdr_left != 4'd0) hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0) begin
                    key_pos = 2'd0;
                    phase   = PH_PAYLOAD;
                    if (frame_len == 64'd0) begin
                        phase = PH_HEAD1;
                        queue_result(8'h00, 1'b1, 1'b1);
                    end
                end
            end
            PH_PAYLOAD: begin
                d = b;
                if (masked) begin
                    d       = b ^ mask_key[key_pos];
                    key_pos = key_pos + 2'd1;
                end
                payload_seen = payload_seen + 64'd1;
                fend         = (payload_seen >= frame_len);
                if (fend) phase = PH_HEAD1;
                queue_result(d, fend, 1'b0);
            end
            default: begin
                hdr0  = b;
                phase = PH_HEAD2;
            end
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        deframe_byte(b);
        n_bytes++;
    endtask

    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic mask_on, input t_len_form form,
                              input logic [63:0] flen, input logic [31:0] key,
                              input int n_payload);
        int i;
        push_byte({fin, rsv, op});
        case (form)
            LEN_SHORT: begin
                push_byte({mask_on, flen[6:0]});
            end
            LEN_EXT16: begin
                push_byte({mask_on, LEN_CODE_16});
                push_byte(flen[15:8]);
                push_byte(flen[7:0]);
            end
            default: begin
                push_byte({mask_on, LEN_CODE_64});
                for (i = 7; i >= 0; i--) push_byte(flen[i*8 +: 8]);
                n_ext64++;
            end
        endcase
        if (mask_on) begin
            for (i = 3; i >= 0; i--) push_byte(key[i*8 +: 8]);
        end
        for (i = 0; i < n_payload; i++) push_byte(8'($urandom_range(255, 0)));
        n_frames++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
        end
    endtask

    task automatic check_result();
        t_deframe_result want;
        if (expected_results.size() == 0) begin
            n_errors++;
            $display("%0t ns: unexpected result, expected none, got tdata 0x%0h",
                     $time, o_m_tdata);
            return;
        end
        want = expected_results.pop_front();
        compare_field("data_byte", want.data_byte, o_m_tdata[7:0]);
        compare_field("frame_opcode", {4'd0, want.opcode}, {4'd0, o_m_tdata[11:8]});
        compare_field("tdata padding", 8'h00, {4'd0, o_m_tdata[15:12]});
        compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, o_m_tlast});
        compare_field("message_end", {7'd0, want.message_end}, {7'd0, o_m_tuser[0]});
        compare_field("empty_frame", {7'd0, want.empty_frame}, {7'd0, o_m_tuser[1]});
        n_results++;
        if (want.empty_frame) n_empty++;
    endtask

    // Check each accepted result, then pick the next ready with random stall bursts
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1)
                check_result();
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
                stall_left = $urandom_range(5, 0);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic int pick_length(input int cap);
        int r;
        r = $urandom_range(99, 0);
        if (r < 15) return 0;
        if (r < 85) return $urandom_range(24, 1);
        return $urandom_range(cap, 1);
    endfunction

    task automatic run_directed_frames();
        gap_pct   = 0;
        stall_pct = 0;
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b0, LEN_SHORT, 64'd1, 32'h0, 1);
        // empty continuation frame, all-zero header
        send_frame(1'b0, 3'd0, OP_CONT, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
        // all first header byte bits set, masked and empty: result comes on the last key byte
        send_frame(1'b1, 3'd7, OP_TOP, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
        // key rotation wraps past the fourth payload byte
        send_frame(1'b1, 3'd3, OP_BINARY, 1'b1, LEN_SHORT, 64'd5, 32'h00FF_55AA, 5);
    endtask

    task automatic run_extended_lengths();
        gap_pct   = 10;
        stall_pct = 10;
        send_frame(1'b1, 3'd0, OP_BINARY, 1'b0, LEN_EXT16, 64'd0, 32'h0, 0);
        send_frame(1'b0, 3'd0, OP_TEXT, 1'b1, LEN_EXT16, 64'd0, 32'h1234_5678, 0);
        send_frame(1'b1, 3'd0, OP_CLOSE, 1'b1, LEN_EXT16, 64'd126, 32'hA5C3_0F81, 126);
        send_frame(1'b1, 3'd0, OP_BINARY, 1'b0, LEN_EXT16, 64'd5, 32'h0, 5);
        send_frame(1'b0, 3'd0, OP_RSVD, 1'b0, LEN_EXT16, 64'd200, 32'h0, 200);
        send_frame(1'b1, 3'd0, OP_PING, 1'b0, LEN_EXT64, 64'd0, 32'h0, 0);
        send_frame(1'b1, 3'd0, OP_PONG, 1'b1, LEN_EXT64, 64'd3, 32'hDEAD_BEEF, 3);
        send_frame(1'b0, 3'd0, OP_CONT, 1'b1, LEN_EXT64, 64'd257, 32'h8001_7FFE, 257);
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b0, LEN_SHORT, 64'd125, 32'h0, 125);
    endtask

    task automatic run_random_frames();
        int         start;
        int         r;
        logic [2:0] rsv;
        logic [3:0] op;
        t_len_form  form;
        int         flen;
        start = n_bytes;
        while (n_bytes - start < RANDOM_BYTES) begin
            // vary idling per frame so quiet stretches sit between busy ones
            r         = $urandom_range(2, 0);
            gap_pct   = (r == 0) ? 0 : (r == 1) ? 10 : 35;
            r         = $urandom_range(2, 0);
            stall_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
            rsv = ($urandom_range(7, 0) == 0) ? 3'($urandom_range(7, 0)) : 3'd0;
            op  = ($urandom_range(4, 0) == 0) ? 4'($urandom_range(15, 0))
                                              : known_ops[$urandom_range(5, 0)];
            r = $urandom_range(99, 0);
            if (r < 65) begin
                form = LEN_SHORT;
                flen = pick_length(125);
            end else if (r < 90) begin
                form = LEN_EXT16;
                flen = pick_length(260);
            end else begin
                form = LEN_EXT64;
                flen = pick_length(260);
            end
            send_frame(1'($urandom_range(1, 0)), rsv, op, 1'($urandom_range(1, 0)), form,
                       64'(flen), $urandom, flen);
        end
    endtask

    task automatic run_back_to_back();
        int i;
        gap_pct   = 0;
        stall_pct = 0;
        for (i = 0; i < 6; i++)
            send_frame(1'($urandom_range(1, 0)), 3'd0, known_ops[$urandom_range(5, 0)],
                       1'($urandom_range(1, 0)), LEN_SHORT, 64'(i * 3), $urandom, i * 3);
        // 16-bit length with its high byte in use
        send_frame(1'b1, 3'd0, OP_BINARY, 1'b1, LEN_EXT16, 64'h0100, $urandom, 256);
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
    endtask

    // Length with its top bit set: the frame never ends, so finish the run inside it
    task automatic run_oversized_length();
        gap_pct   = 0;
        stall_pct = 0;
        send_frame(1'b1, 3'd0, OP_BINARY, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0010,
                   $urandom, 40);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_s_tvalid   <= 1'b0;
        i_s_tdata    <= 8'h00;
        phase        = PH_HEAD1;
        hdr0         = 8'h00;
        masked       = 1'b0;
        hdr_left     = 4'd0;
        frame_len    = 64'd0;
        payload_seen = 64'd0;
        key_pos      = 2'd0;
        gap_pct      = 0;
        stall_pct    = 0;
        stall_left   = 0;
        n_errors     = 0;
        n_bytes      = 0;
        n_frames     = 0;
        n_results    = 0;
        n_empty      = 0;
        n_ext64      = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed_frames();
        run_extended_lengths();
        run_random_frames();
        run_back_to_back();
        run_oversized_length();
        i_s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d frames in %0d stream bytes (%0d with 64-bit lengths).",
                 n_frames, n_bytes, n_ext64);
        $display("Checked %0d results, %0d of them empty frames, with %0d errors.",
                 n_results, n_empty, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
